@@ rtl/core/curtain_event_controller_defines.svh @@
// ----------------------------------------------------------------------------
// Curtain event controller assertion macros
// Shared property shorthands for the checker, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef CURTAIN_EVENT_CONTROLLER_DEFINES_SVH
`define CURTAIN_EVENT_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define CEC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CEC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/cec_pkg.sv @@
// ----------------------------------------------------------------------------
// Curtain event controller package
// Event kinds, state codes, result field layout.
// ----------------------------------------------------------------------------
package cec_pkg;

  localparam int unsigned KindW    = 3;
  localparam int unsigned ParamW   = 8;
  localparam int unsigned OutDataW = 48;

  typedef logic [2:0] state_t;
  typedef logic [1:0] mode_t;
  typedef logic [1:0] pos_t;
  typedef logic [2:0] focus_t;
  typedef logic [1:0] motor_t;

  // event kinds
  localparam logic [KindW-1:0] KIND_KEY    = 3'd0;
  localparam logic [KindW-1:0] KIND_LIGHT  = 3'd1;
  localparam logic [KindW-1:0] KIND_SCHED  = 3'd2;
  localparam logic [KindW-1:0] KIND_MOTOR  = 3'd3;
  localparam logic [KindW-1:0] KIND_CO     = 3'd4;

  // machine states
  localparam state_t ST_IDLE_LUX  = 3'd0;
  localparam state_t ST_IDLE_TIM  = 3'd1;
  localparam state_t ST_IDLE_MAN  = 3'd2;
  localparam state_t ST_OPENING   = 3'd3;
  localparam state_t ST_CLOSING   = 3'd4;
  localparam state_t ST_SET_OPEN  = 3'd5;
  localparam state_t ST_SET_CLOSE = 3'd6;
  localparam state_t ST_SET_CLOCK = 3'd7;

  localparam mode_t MD_LUX = 2'd0;
  localparam mode_t MD_TIM = 2'd1;
  localparam mode_t MD_MAN = 2'd2;

  localparam pos_t POS_OPENED  = 2'd0;
  localparam pos_t POS_OPENING = 2'd1;
  localparam pos_t POS_CLOSED  = 2'd2;
  localparam pos_t POS_CLOSING = 2'd3;

  localparam focus_t FC_NONE  = 3'd0;
  localparam focus_t FC_HOUR  = 3'd1;
  localparam focus_t FC_MIN   = 3'd2;
  localparam focus_t FC_OPEN  = 3'd3;
  localparam focus_t FC_CLOSE = 3'd4;

  localparam motor_t MOTOR_NONE  = 2'd0;
  localparam motor_t MOTOR_OPEN  = 2'd1;
  localparam motor_t MOTOR_CLOSE = 2'd2;

  // key operations
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_MODE  = 3'd1;
  localparam logic [2:0] OP_UP    = 3'd2;
  localparam logic [2:0] OP_DOWN  = 3'd3;
  localparam logic [2:0] OP_ENTER = 3'd4;

  localparam logic [1:0] STB_BEEP  = 2'b01;
  localparam logic [1:0] STB_CLOCK = 2'b10;

  localparam logic [4:0] HOUR_MAX     = 5'd23;
  localparam logic [5:0] MINUTE_MAX   = 6'd59;
  localparam logic [4:0] OPEN_HOUR_RST  = 5'd8;
  localparam logic [4:0] CLOSE_HOUR_RST = 5'd18;

  // result field positions in m_axis_tdata
  localparam int unsigned O_MOTOR = 0;
  localparam int unsigned O_STB   = 2;
  localparam int unsigned O_CHR   = 4;
  localparam int unsigned O_CMIN  = 9;
  localparam int unsigned O_STATE = 15;
  localparam int unsigned O_MODE  = 18;
  localparam int unsigned O_POS   = 20;
  localparam int unsigned O_FOCUS = 22;
  localparam int unsigned O_OPEN  = 25;
  localparam int unsigned O_CLOSE = 30;
  localparam int unsigned O_EDIT  = 35;
  localparam int unsigned O_SENS  = 40;
  localparam int unsigned O_USED  = 42;

endpackage

@@ rtl/core/curtain_event_controller.sv @@
// ----------------------------------------------------------------------------
// Curtain event controller
// Event-driven control of a motorized curtain: modes, schedule, clock edit.
// ----------------------------------------------------------------------------
// One event enters per clock while the result side accepts, and every event
// yields one status result: the event is held in the input register, then
// the decision logic updates the controller state and loads the result register.
// Sustained rate is one event per cycle; only a stalled result side slows
// the input, through the result register's ready.
module curtain_event_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // param
  input  logic [cec_pkg::KindW-1:0]     s_axis_tuser,  // kind
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // motor_cmd, strobes, clock_hour, clock_minute, machine_state, mode_now,
  // curtain_now, focus_now, open_at, close_at, edit_hour, sensor_flags
  output logic [cec_pkg::OutDataW-1:0]  m_axis_tdata
);
  import cec_pkg::*;

  function automatic logic [5:0] wrap_up(logic [5:0] v, logic [5:0] top);
    return (v < top) ? v + 6'd1 : 6'd0;
  endfunction

  function automatic logic [5:0] wrap_down(logic [5:0] v, logic [5:0] top);
    return (v > 6'd0 && v <= top) ? v - 6'd1 : top;
  endfunction

  logic                  in_vld_q, out_vld_q, adv;
  logic [KindW-1:0]      kind_q;
  logic [ParamW-1:0]     param_q;
  logic [OutDataW-1:0]   out_q, out_d;

  state_t     state_q, state_d;
  mode_t      mode_q, mode_d;
  pos_t       pos_q, pos_d;
  focus_t     focus_q, focus_d;
  logic       lux_q, lux_d, co_q, co_d;
  logic [4:0] open_q, open_d, close_q, close_d, edit_q, edit_d, hour_q, hour_d;
  logic [5:0] min_q, min_d;
  logic [5:0] wrap_v;
  motor_t     motor;
  logic [1:0] stb;
  logic [2:0] op;
  logic       handled, start_open, start_close, to_idle;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    state_d = state_q;  mode_d = mode_q;  pos_d = pos_q;  focus_d = focus_q;
    lux_d = lux_q;  co_d = co_q;  open_d = open_q;  close_d = close_q;
    edit_d = edit_q;  hour_d = hour_q;  min_d = min_q;
    stb = 2'b00;  handled = 1'b0;  wrap_v = '0;
    start_open = 1'b0;  start_close = 1'b0;  to_idle = 1'b0;

    op = OP_NONE;
    if (param_q >= 8'd1 && param_q <= 8'd4) begin
      if (mode_q == MD_LUX) begin
        op = (param_q == 8'd1) ? OP_MODE : OP_NONE;
      end else if (mode_q == MD_TIM || mode_q == MD_MAN) begin
        op = param_q[2:0];
      end
    end

    if (kind_q == KIND_CO && param_q == 8'd1) begin
      co_d = 1'b1;
      stb  = stb | STB_BEEP;
      if (pos_q != POS_OPENED && state_q != ST_OPENING) begin
        start_open = 1'b1;
        handled    = 1'b1;
      end
    end

    if (!handled) begin
      if (kind_q == KIND_KEY) begin
        case (state_q)
          ST_IDLE_LUX: begin
            if (op == OP_MODE) to_idle = 1'b1;
          end
          ST_IDLE_TIM: begin
            if (op == OP_MODE) begin
              to_idle = 1'b1;
            end else if (op == OP_ENTER) begin
              state_d = ST_SET_OPEN;
              edit_d  = open_q;
              focus_d = FC_OPEN;
            end
          end
          ST_IDLE_MAN: begin
            if (op == OP_MODE) begin
              to_idle = 1'b1;
            end else if (op == OP_UP) begin
              start_open = (pos_q == POS_CLOSED);
            end else if (op == OP_DOWN) begin
              start_close = (pos_q == POS_OPENED);
            end else if (op == OP_ENTER) begin
              state_d = ST_SET_CLOCK;
              focus_d = FC_HOUR;
            end
          end
          ST_SET_OPEN, ST_SET_CLOSE: begin
            if (op == OP_UP) begin
              wrap_v = wrap_up({1'b0, edit_q}, {1'b0, HOUR_MAX});
              edit_d = wrap_v[4:0];
            end else if (op == OP_DOWN) begin
              wrap_v = wrap_down({1'b0, edit_q}, {1'b0, HOUR_MAX});
              edit_d = wrap_v[4:0];
            end else if (op == OP_ENTER) begin
              if (state_q == ST_SET_OPEN) begin
                open_d  = edit_q;
                state_d = ST_SET_CLOSE;
                edit_d  = close_q;
                focus_d = FC_CLOSE;
              end else begin
                close_d = edit_q;
                state_d = ST_IDLE_TIM;
                focus_d = FC_NONE;
              end
            end
          end
          ST_SET_CLOCK: begin
            if (op == OP_UP) begin
              if (focus_q == FC_HOUR) begin
                wrap_v = wrap_up({1'b0, hour_q}, {1'b0, HOUR_MAX});
                hour_d = wrap_v[4:0];
              end else if (focus_q == FC_MIN) begin
                min_d = wrap_up(min_q, MINUTE_MAX);
              end
            end else if (op == OP_DOWN) begin
              if (focus_q == FC_HOUR) begin
                wrap_v = wrap_down({1'b0, hour_q}, {1'b0, HOUR_MAX});
                hour_d = wrap_v[4:0];
              end else if (focus_q == FC_MIN) begin
                min_d = wrap_down(min_q, MINUTE_MAX);
              end
            end else if (op == OP_ENTER) begin
              if (focus_q == FC_HOUR) begin
                focus_d = FC_MIN;
              end else if (focus_q == FC_MIN) begin
                stb     = stb | STB_CLOCK;
                state_d = ST_IDLE_MAN;
                focus_d = FC_NONE;
              end
            end
          end
          default: ;
        endcase
      end else if (kind_q == KIND_LIGHT && state_q == ST_IDLE_LUX) begin
        lux_d       = (param_q == 8'd1);
        start_open  = (param_q == 8'd1) && (pos_q == POS_CLOSED);
        start_close = (param_q != 8'd1) && (pos_q == POS_OPENED);
      end else if (kind_q == KIND_SCHED && state_q == ST_IDLE_TIM) begin
        start_open  = (param_q == 8'd1) && (pos_q == POS_CLOSED);
        start_close = (param_q != 8'd1) && (pos_q == POS_OPENED);
      end else if (kind_q == KIND_MOTOR && param_q == 8'd0 &&
                   (state_q == ST_OPENING || state_q == ST_CLOSING)) begin
        pos_d = (state_q == ST_OPENING) ? POS_OPENED : POS_CLOSED;
        case (mode_q)
          MD_LUX:  state_d = ST_IDLE_LUX;
          MD_TIM:  state_d = ST_IDLE_TIM;
          default: state_d = ST_IDLE_MAN;
        endcase
      end
    end

    // mode key: step the mode, land in its idle state
    if (to_idle) begin
      case (mode_q)
        MD_LUX: begin
          mode_d = MD_TIM;  state_d = ST_IDLE_TIM;
        end
        MD_TIM: begin
          mode_d = MD_MAN;  state_d = ST_IDLE_MAN;
        end
        default: begin
          mode_d = MD_LUX;  state_d = ST_IDLE_LUX;
        end
      endcase
    end

    motor = MOTOR_NONE;
    if (start_open) begin
      state_d = ST_OPENING;  pos_d = POS_OPENING;  motor = MOTOR_OPEN;
    end else if (start_close) begin
      state_d = ST_CLOSING;  pos_d = POS_CLOSING;  motor = MOTOR_CLOSE;
    end

    out_d = {{(OutDataW - O_USED){1'b0}}, co_d, lux_d, edit_d, close_d, open_d,
             focus_d, pos_d, mode_d, state_d, min_d, hour_d, stb, motor};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= ST_IDLE_MAN;
      mode_q    <= MD_MAN;
      pos_q     <= POS_OPENED;
      focus_q   <= FC_NONE;
      lux_q     <= 1'b1;
      co_q      <= 1'b0;
      open_q    <= OPEN_HOUR_RST;
      close_q   <= CLOSE_HOUR_RST;
      edit_q    <= '0;
      hour_q    <= '0;
      min_q     <= '0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (adv) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
        mode_q    <= mode_d;
        pos_q     <= pos_d;
        focus_q   <= focus_d;
        lux_q     <= lux_d;
        co_q      <= co_d;
        open_q    <= open_d;
        close_q   <= close_d;
        edit_q    <= edit_d;
        hour_q    <= hour_d;
        min_q     <= min_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      kind_q  <= s_axis_tuser;
      param_q <= s_axis_tdata;
    end
    if (adv) out_q <= out_d;
  end

endmodule

@@ rtl/core/cec_checker.sv @@
// ----------------------------------------------------------------------------
// Curtain event controller checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "curtain_event_controller_defines.svh"

module cec_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [7:0]                    s_axis_tdata,
  input logic [cec_pkg::KindW-1:0]     s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [cec_pkg::OutDataW-1:0]  m_axis_tdata
);
  import cec_pkg::*;

  motor_t     motor;
  logic [1:0] stb;
  state_t     st;
  pos_t       pos;
  focus_t     foc;
  logic       co;

  assign motor = m_axis_tdata[O_MOTOR +: 2];
  assign stb   = m_axis_tdata[O_STB +: 2];
  assign st    = m_axis_tdata[O_STATE +: 3];
  assign pos   = m_axis_tdata[O_POS +: 2];
  assign foc   = m_axis_tdata[O_FOCUS +: 3];
  assign co    = m_axis_tdata[O_SENS + 1];

  `CEC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `CEC_ASSERT_IMP(a_open_cmd, m_axis_tvalid && motor == MOTOR_OPEN, st == ST_OPENING && pos == POS_OPENING, "open command without opening status")
  `CEC_ASSERT_IMP(a_close_cmd, m_axis_tvalid && motor == MOTOR_CLOSE, st == ST_CLOSING && pos == POS_CLOSING, "close command without closing status")
  `CEC_ASSERT_IMP(a_clock_wr, m_axis_tvalid && stb[1], st == ST_IDLE_MAN && foc == FC_NONE && !stb[0] && motor == MOTOR_NONE, "clock write outside clock confirm")
  `CEC_ASSERT_IMP(a_beep_co, m_axis_tvalid && stb[0], co, "beep without CO flag")

  logic unused_in;
  assign unused_in = ^{s_axis_tvalid, s_axis_tready, s_axis_tdata, s_axis_tuser};

endmodule

bind curtain_event_controller cec_checker u_cec_checker (.*);

@@ sim/tb_curtain_event_controller.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Curtain event controller testbench
// Drives key, light, schedule, motor and CO events into the request stream,
// predicts each status result in a behavioral model of the controller and
// compares every returned result field by field, under varied flow control.
// ----------------------------------------------------------------------------
module tb_curtain_event_controller;
  import cec_pkg::*;

  localparam logic [7:0] KEY_MODE  = 8'd1;
  localparam logic [7:0] KEY_UP    = 8'd2;
  localparam logic [7:0] KEY_DOWN  = 8'd3;
  localparam logic [7:0] KEY_ENTER = 8'd4;
  localparam logic [7:0] FLAG_ON   = 8'd1;
  localparam logic [7:0] MOTOR_DONE = 8'd0;
  localparam int QUIET_LIMIT = 1000;

  typedef struct {
    motor_t     motor;
    logic [1:0] strobes;
    logic [4:0] clk_hour;
    logic [5:0] clk_min;
    state_t     state;
    mode_t      mode;
    pos_t       pos;
    focus_t     focus;
    logic [4:0] open_hr;
    logic [4:0] close_hr;
    logic [4:0] edit_hr;
    logic [1:0] sensors;
  } curtain_status_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // param
  logic [KindW-1:0]    s_axis_tuser = '0;   // kind
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // motor_cmd, strobes, clock_hour, clock_minute, machine_state, mode_now,
  // curtain_now, focus_now, open_at, close_at, edit_hour, sensor_flags
  logic [OutDataW-1:0] m_axis_tdata;

  // controller model state
  state_t     cur_state = ST_IDLE_MAN;
  mode_t      cur_mode = MD_MAN;
  pos_t       cur_pos = POS_OPENED;
  focus_t     cur_focus = FC_NONE;
  logic       lux_bright = 1'b1;
  logic       co_alarm = 1'b0;
  logic [4:0] open_hr = OPEN_HOUR_RST;
  logic [4:0] close_hr = CLOSE_HOUR_RST;
  logic [4:0] sched_edit_hr = '0;
  logic [4:0] clk_hr_edit = '0;
  logic [5:0] clk_min_edit = '0;

  curtain_status_t pending_status_q[$];
  int fail_cnt = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int holdoff_req = 0;
  int holdoff_left = 0;
  int quiet_cycles = 0;

  curtain_event_controller dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model
  function automatic int step_up(int v, int top);
    return (v < top) ? v + 1 : 0;
  endfunction

  function automatic int step_down(int v, int top);
    return (v > 0 && v <= top) ? v - 1 : top;
  endfunction

  function automatic state_t idle_state();
    if (cur_mode == MD_LUX) return ST_IDLE_LUX;
    if (cur_mode == MD_TIM) return ST_IDLE_TIM;
    return ST_IDLE_MAN;
  endfunction

  function automatic motor_t start_motion(bit opening);
    cur_state = opening ? ST_OPENING : ST_CLOSING;
    cur_pos   = opening ? POS_OPENING : POS_CLOSING;
    return opening ? MOTOR_OPEN : MOTOR_CLOSE;
  endfunction

  function automatic curtain_status_t apply_event(logic [2:0] kind, logic [7:0] param);
    curtain_status_t r;
    logic [2:0] op;
    motor_t motor;
    logic [1:0] stb;
    bit co_took;
    motor = MOTOR_NONE;
    stb = '0;
    co_took = 0;
    if (kind == KIND_CO && param == FLAG_ON) begin
      co_alarm = 1'b1;
      stb |= STB_BEEP;
      if (cur_pos != POS_OPENED && cur_state != ST_OPENING) begin
        motor = start_motion(1'b1);
        co_took = 1;
      end
    end
    if (!co_took) begin
      if (kind == KIND_KEY) begin
        // key codes 1..4 coincide with the mode/up/down/enter op codes
        op = OP_NONE;
        if (param >= KEY_MODE && param <= KEY_ENTER) begin
          if (cur_mode == MD_LUX) op = (param == KEY_MODE) ? OP_MODE : OP_NONE;
          else op = param[2:0];
        end
        case (cur_state)
          ST_IDLE_LUX: begin
            if (op == OP_MODE) begin
              cur_mode = MD_TIM;
              cur_state = idle_state();
            end
          end
          ST_IDLE_TIM: begin
            if (op == OP_MODE) begin
              cur_mode = MD_MAN;
              cur_state = idle_state();
            end else if (op == OP_ENTER) begin
              cur_state = ST_SET_OPEN;
              sched_edit_hr = open_hr;
              cur_focus = FC_OPEN;
            end
          end
          ST_IDLE_MAN: begin
            if (op == OP_MODE) begin
              cur_mode = MD_LUX;
              cur_state = idle_state();
            end else if (op == OP_UP) begin
              if (cur_pos == POS_CLOSED) motor = start_motion(1'b1);
            end else if (op == OP_DOWN) begin
              if (cur_pos == POS_OPENED) motor = start_motion(1'b0);
            end else if (op == OP_ENTER) begin
              cur_state = ST_SET_CLOCK;
              cur_focus = FC_HOUR;
            end
          end
          ST_SET_OPEN, ST_SET_CLOSE: begin
            if (op == OP_UP) begin
              sched_edit_hr = 5'(step_up(int'(sched_edit_hr), int'(HOUR_MAX)));
            end else if (op == OP_DOWN) begin
              sched_edit_hr = 5'(step_down(int'(sched_edit_hr), int'(HOUR_MAX)));
            end else if (op == OP_ENTER) begin
              if (cur_state == ST_SET_OPEN) begin
                open_hr = sched_edit_hr;
                cur_state = ST_SET_CLOSE;
                sched_edit_hr = close_hr;
                cur_focus = FC_CLOSE;
              end else begin
                close_hr = sched_edit_hr;
                cur_state = ST_IDLE_TIM;
                cur_focus = FC_NONE;
              end
            end
          end
          ST_SET_CLOCK: begin
            if (op == OP_UP) begin
              if (cur_focus == FC_HOUR)
                clk_hr_edit = 5'(step_up(int'(clk_hr_edit), int'(HOUR_MAX)));
              else if (cur_focus == FC_MIN)
                clk_min_edit = 6'(step_up(int'(clk_min_edit), int'(MINUTE_MAX)));
            end else if (op == OP_DOWN) begin
              if (cur_focus == FC_HOUR)
                clk_hr_edit = 5'(step_down(int'(clk_hr_edit), int'(HOUR_MAX)));
              else if (cur_focus == FC_MIN)
                clk_min_edit = 6'(step_down(int'(clk_min_edit), int'(MINUTE_MAX)));
            end else if (op == OP_ENTER) begin
              if (cur_focus == FC_HOUR) cur_focus = FC_MIN;
              else if (cur_focus == FC_MIN) begin
                stb |= STB_CLOCK;
                cur_state = ST_IDLE_MAN;
                cur_focus = FC_NONE;
              end
            end
          end
          default: ;
        endcase
      end else if (kind == KIND_LIGHT && cur_state == ST_IDLE_LUX) begin
        if (param == FLAG_ON) begin
          lux_bright = 1'b1;
          if (cur_pos == POS_CLOSED) motor = start_motion(1'b1);
        end else begin
          lux_bright = 1'b0;
          if (cur_pos == POS_OPENED) motor = start_motion(1'b0);
        end
      end else if (kind == KIND_SCHED && cur_state == ST_IDLE_TIM) begin
        if (param == FLAG_ON) begin
          if (cur_pos == POS_CLOSED) motor = start_motion(1'b1);
        end else if (cur_pos == POS_OPENED) motor = start_motion(1'b0);
      end else if (kind == KIND_MOTOR && param == MOTOR_DONE &&
                   (cur_state == ST_OPENING || cur_state == ST_CLOSING)) begin
        cur_pos = (cur_state == ST_OPENING) ? POS_OPENED : POS_CLOSED;
        cur_state = idle_state();
      end
    end
    r.motor    = motor;
    r.strobes  = stb;
    r.clk_hour = clk_hr_edit;
    r.clk_min  = clk_min_edit;
    r.state    = cur_state;
    r.mode     = cur_mode;
    r.pos      = cur_pos;
    r.focus    = cur_focus;
    r.open_hr  = open_hr;
    r.close_hr = close_hr;
    r.edit_hr  = sched_edit_hr;
    r.sensors  = {co_alarm, lux_bright};
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    curtain_status_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_status_q.size() == 0) begin
        $error("unexpected result 0x%012h", m_axis_tdata);
        fail_cnt++;
      end else begin
        want = pending_status_q.pop_front();
        check_field("motor_cmd", want.motor, m_axis_tdata[O_MOTOR +: 2]);
        check_field("strobes", want.strobes, m_axis_tdata[O_STB +: 2]);
        check_field("clock_hour", want.clk_hour, m_axis_tdata[O_CHR +: 5]);
        check_field("clock_minute", want.clk_min, m_axis_tdata[O_CMIN +: 6]);
        check_field("machine_state", want.state, m_axis_tdata[O_STATE +: 3]);
        check_field("mode_now", want.mode, m_axis_tdata[O_MODE +: 2]);
        check_field("curtain_now", want.pos, m_axis_tdata[O_POS +: 2]);
        check_field("focus_now", want.focus, m_axis_tdata[O_FOCUS +: 3]);
        check_field("open_at", want.open_hr, m_axis_tdata[O_OPEN +: 5]);
        check_field("close_at", want.close_hr, m_axis_tdata[O_CLOSE +: 5]);
        check_field("edit_hour", want.edit_hr, m_axis_tdata[O_EDIT +: 5]);
        check_field("sensor_flags", want.sensors, m_axis_tdata[O_SENS +: 2]);
      end
    end
  end

  // ---------------------------------------------------------------- flow control
  always @(posedge clk_i) begin
    if (holdoff_req > 0) begin
      holdoff_left = holdoff_req;
      holdoff_req = 0;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("[curtain_event_controller] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_event(logic [2:0] kind, logic [7:0] param);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= param;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_status_q.push_back(apply_event(kind, param));
  endtask

  task automatic await_results();
    s_axis_tvalid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] flag_value();
    if ($urandom_range(4) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(1));
  endfunction

  task automatic send_random_event();
    int pick;
    logic [2:0] kind;
    logic [7:0] param;
    pick = $urandom_range(99);
    if (pick < 45) begin
      kind = KIND_KEY;
      param = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(4, 1));
    end else if (pick < 65) begin
      kind = KIND_MOTOR;
      param = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : MOTOR_DONE;
    end else if (pick < 77) begin
      kind = KIND_LIGHT;
      param = flag_value();
    end else if (pick < 89) begin
      kind = KIND_SCHED;
      param = flag_value();
    end else if (pick < 96) begin
      kind = KIND_CO;
      param = flag_value();
    end else begin
      kind = 3'($urandom_range(7, 5));
      param = 8'($urandom_range(255));
    end
    send_event(kind, param);
  endtask

  task automatic run_random(int count, int idle_pct, int stall);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    repeat (count) send_random_event();
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    send_event(3'd5, 8'd0);             // unknown kinds
    send_event(3'd7, 8'd255);
    send_event(KIND_KEY, 8'd0);         // unknown key codes
    send_event(KIND_KEY, 8'd255);
    send_event(KIND_KEY, KEY_ENTER);    // clock edit, hour focus
    send_event(KIND_KEY, KEY_DOWN);     // hour wraps 0 -> 23
    send_event(KIND_KEY, KEY_UP);       // 23 -> 0
    send_event(KIND_KEY, KEY_ENTER);    // minute focus
    send_event(KIND_KEY, KEY_DOWN);     // minute wraps 0 -> 59
    send_event(KIND_KEY, KEY_UP);       // 59 -> 0
    send_event(KIND_KEY, KEY_ENTER);    // clock write
    send_event(KIND_KEY, KEY_DOWN);     // manual close
    send_event(KIND_MOTOR, 8'd255);     // busy
    send_event(KIND_MOTOR, MOTOR_DONE);
    send_event(KIND_LIGHT, FLAG_ON);    // light outside light mode
    send_event(KIND_KEY, KEY_MODE);     // manual -> light
    send_event(KIND_LIGHT, FLAG_ON);
    send_event(KIND_MOTOR, MOTOR_DONE);
    send_event(KIND_KEY, KEY_MODE);     // light -> time
    send_event(KIND_SCHED, 8'd200);     // close trigger
    send_event(KIND_MOTOR, MOTOR_DONE);
    send_event(KIND_KEY, KEY_ENTER);    // schedule edit
    send_event(KIND_CO, FLAG_ON);       // CO aborts edit, opens
    send_event(KIND_CO, 8'd0);          // CO low
    send_event(KIND_CO, FLAG_ON);       // already opening: beep only
  endtask

  task automatic test_streaming();
    run_random(150, 0, 0);
  endtask

  task automatic test_sender_gaps();
    run_random(200, 82, 0);
  endtask

  task automatic test_receiver_stalls();
    run_random(200, 0, 82);
  endtask

  task automatic test_mixed_gaps();
    run_random(200, 34, 34);
  endtask

  task automatic test_backpressure();
    holdoff_req = 80;
    run_random(30, 0, 0);
  endtask

  task automatic test_drain_pause();
    run_random(60, 10, 10);
    await_results();
    run_random(60, 10, 10);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_gaps();
    test_backpressure();
    test_drain_pause();
    await_results();
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0 && pending_status_q.size() == 0)
      $display("[curtain_event_controller] OK");
    else
      $display("[curtain_event_controller] ERROR");
    $finish;
  end

endmodule
